@@ sv/prte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair relation table engine package
// Shared widths, opcodes, status codes and the control word that the
// controller broadcasts to every cell of the table chain.
// ----------------------------------------------------------------------------
package prte_pkg;

  // Fixed field widths of the request and response channels.
  localparam int OPCODE_W    = 3;
  localparam int ID_IN_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_IDX_W = 8;
  localparam int COUNT_W     = 9;

  // Default sizing of the table.
  localparam int ENTRIES_DEF  = 256;
  localparam int ID_WIDTH_DEF = 32;

  // Request opcodes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_PURGE_FILE = 3'd2,
    OP_PURGE_TAG  = 3'd3,
    OP_SEARCH     = 3'd4
  } opcode_e;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Control word shared by all cells in one cycle.
  typedef struct packed {
    logic shift;  // every cell takes its right neighbor
    logic wr;     // the cell whose index matches takes the write data
  } cell_ctl_t;

endpackage

@@ sv/prte_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair relation table request channel
// Valid/ready channel carrying one table request.
// ----------------------------------------------------------------------------
interface prte_req_if import prte_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ID_IN_W-1:0]  file_id;
  logic [ID_IN_W-1:0]  tag_id;

  modport source (output valid, output opcode, output file_id, output tag_id,
                  input ready);
  modport sink (input valid, input opcode, input file_id, input tag_id,
                output ready);

endinterface

@@ sv/prte_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair relation table response channel
// Valid/ready channel carrying the result of one table request.
// ----------------------------------------------------------------------------
interface prte_rsp_if import prte_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic [COUNT_W-1:0]     removed_count;
  logic [COUNT_W-1:0]     entry_count;

  modport source (output valid, output status, output entry_index,
                  output removed_count, output entry_count, input ready);
  modport sink (input valid, input status, input entry_index,
                input removed_count, input entry_count, output ready);

endinterface

@@ sv/prte_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair relation table cell
// Holds one (file, tag) pair. It either keeps its pair, takes the pair of
// its right neighbor, or takes the broadcast write data when addressed.
// ----------------------------------------------------------------------------
module prte_cell import prte_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF,
  parameter int INDEX    = 0
) (
  input  logic                         clk,
  input  cell_ctl_t                    ctl,
  input  logic [$clog2(ENTRIES)-1:0]   wr_idx,
  input  logic [ID_WIDTH-1:0]          wr_file,
  input  logic [ID_WIDTH-1:0]          wr_tag,
  input  logic [ID_WIDTH-1:0]          nbr_file,
  input  logic [ID_WIDTH-1:0]          nbr_tag,
  output logic [ID_WIDTH-1:0]          file_q,
  output logic [ID_WIDTH-1:0]          tag_q
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  // An addressed write wins over the shift from the neighbor.
  always_ff @(posedge clk) begin
    if (ctl.wr && (wr_idx == MY_IDX)) begin
      file_q <= wr_file;
      tag_q  <= wr_tag;
    end else if (ctl.shift) begin
      file_q <= nbr_file;
      tag_q  <= nbr_tag;
    end
  end

endmodule

@@ sv/prte_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair relation table controller
// Takes requests, steers one full revolution of the cell chain past the
// compare head, keeps the entry count and registers the response.
// ----------------------------------------------------------------------------
module prte_ctrl import prte_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  prte_req_if.sink                    req,
  prte_rsp_if.source                  rsp,
  input  logic [ID_WIDTH-1:0]         head_file,
  input  logic [ID_WIDTH-1:0]         head_tag,
  output cell_ctl_t                   ctl,
  output logic [$clog2(ENTRIES)-1:0]  wr_idx,
  output logic [ID_WIDTH-1:0]         wr_file,
  output logic [ID_WIDTH-1:0]         wr_tag
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t               state;
  opcode_e              op;
  logic [ID_WIDTH-1:0]  key_file;
  logic [ID_WIDTH-1:0]  key_tag;
  logic [IDX_W-1:0]     scan_idx;
  logic [IDX_W-1:0]     wp;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic [CNT_W-1:0]     removed;
  logic [CNT_W-1:0]     count;
  logic                 out_valid;
  status_e              out_status;
  logic [ENTRY_IDX_W-1:0] out_index;
  logic [COUNT_W-1:0]   out_removed;
  logic [COUNT_W-1:0]   out_count;

  logic                 in_range;
  logic                 pair_match;
  logic                 drop;
  logic                 keep;
  logic                 done_fire;
  logic                 do_insert;
  status_e              res_status;
  logic [ENTRY_IDX_W-1:0] res_index;
  logic [CNT_W-1:0]     count_next;

  // Compare the pair at the head of the chain against the request key.
  always_comb begin
    in_range   = (CNT_W'(scan_idx) < count);
    pair_match = (head_file == key_file) && (head_tag == key_tag);
    case (op)
      OP_REMOVE:     drop = in_range && pair_match && !hit;
      OP_PURGE_FILE: drop = in_range && (head_file == key_file);
      OP_PURGE_TAG:  drop = in_range && (head_tag == key_tag);
      default:       drop = 1'b0;
    endcase
    keep = in_range && !drop;
  end

  // Finish the request once the response register is free.
  assign done_fire = (state == S_DONE) && (!out_valid || rsp.ready);
  assign do_insert = (op == OP_INSERT) && !hit && (count != FULL_CNT);

  // Cell control: shift with compaction writes while scanning, then an
  // optional append at the end of the table.
  always_comb begin
    ctl.shift = 1'b0;
    ctl.wr    = 1'b0;
    wr_idx    = wp;
    wr_file   = head_file;
    wr_tag    = head_tag;
    if (state == S_SCAN) begin
      ctl.shift = 1'b1;
      ctl.wr    = keep;
    end else if (done_fire && do_insert) begin
      ctl.wr  = 1'b1;
      wr_idx  = IDX_W'(count);
      wr_file = key_file;
      wr_tag  = key_tag;
    end
  end

  // Response fields and the entry count after the request.
  always_comb begin
    res_status = ST_OK;
    res_index  = '0;
    count_next = count - removed;
    case (op)
      OP_INSERT: begin
        if (hit) begin
          res_status = ST_DUP;
          res_index  = ENTRY_IDX_W'(hit_idx);
        end else if (count == FULL_CNT) begin
          res_status = ST_FULL;
        end else begin
          res_index  = ENTRY_IDX_W'(count);
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE, OP_SEARCH: begin
        if (hit) begin
          res_index = ENTRY_IDX_W'(hit_idx);
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      OP_PURGE_FILE, OP_PURGE_TAG: begin
        res_status = ST_OK;
      end
      default: begin
        res_status = ST_NOTFOUND;
      end
    endcase
  end

  // State, scan registers and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      hit       <= 1'b0;
      removed   <= '0;
      scan_idx  <= '0;
      wp        <= LAST_IDX;
    end else begin
      // A response taken in the cycle a new one is loaded is replaced below.
      if (out_valid && rsp.ready && !done_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op       <= opcode_e'(req.opcode);
            key_file <= ID_WIDTH'(req.file_id);
            key_tag  <= ID_WIDTH'(req.tag_id);
            scan_idx <= '0;
            wp       <= LAST_IDX;
            hit      <= 1'b0;
            hit_idx  <= '0;
            removed  <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Kept pairs land at the write pointer; a dropped one leaves it
          // one place lower for the pairs behind it.
          if (!keep) begin
            wp <= wp - IDX_W'(1);
          end
          if (drop) begin
            removed <= removed + CNT_W'(1);
          end
          if (in_range && pair_match && !hit) begin
            hit     <= 1'b1;
            hit_idx <= scan_idx;
          end
          scan_idx <= scan_idx + IDX_W'(1);
          if (scan_idx == LAST_IDX) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            count       <= count_next;
            out_valid   <= 1'b1;
            out_status  <= res_status;
            out_index   <= res_index;
            out_removed <= COUNT_W'(removed);
            out_count   <= COUNT_W'(count_next);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.entry_index   = out_index;
  assign rsp.removed_count = out_removed;
  assign rsp.entry_count   = out_count;

endmodule

@@ sv/pair_relation_table_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair relation table engine
// Ordered table of (file, tag) pairs with insert, remove, purge and search.
// ----------------------------------------------------------------------------
// The table lives in a ring of ENTRIES cells, one pair per cell. Every
// request, whatever its opcode, goes from acceptance to a valid response
// through the scan state, in which the whole ring rotates once past the
// single compare unit at its head, and the done state, which updates the
// entry count and loads the response register. The request channel is ready
// again in the cycle after that, so a new request is taken only once the
// response to the last one has been loaded.
// The duplicate check, the search and the order-preserving compaction all
// happen during that one revolution, so the ring length sets the rate.
// A new request is taken while an earlier response still waits to be
// taken; it then holds in its last cycle until the response register is
// free. Reset clears the count and control state; cells need no clearing.
module pair_relation_table_engine_core import prte_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  prte_req_if.sink   req,
  prte_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(ENTRIES);

  cell_ctl_t           ctl;
  logic [IDX_W-1:0]    wr_idx;
  logic [ID_WIDTH-1:0] wr_file;
  logic [ID_WIDTH-1:0] wr_tag;
  logic [ID_WIDTH-1:0] cell_file [ENTRIES];
  logic [ID_WIDTH-1:0] cell_tag  [ENTRIES];

  // Controller with the compare head on cell zero.
  prte_ctrl #(
    .ENTRIES  (ENTRIES),
    .ID_WIDTH (ID_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .head_file (cell_file[0]),
    .head_tag  (cell_tag[0]),
    .ctl       (ctl),
    .wr_idx    (wr_idx),
    .wr_file   (wr_file),
    .wr_tag    (wr_tag)
  );

  // Ring of cells; each one shifts toward cell zero, the last wraps around.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    localparam int NBR = (i == ENTRIES - 1) ? 0 : i + 1;
    prte_cell #(
      .ENTRIES  (ENTRIES),
      .ID_WIDTH (ID_WIDTH),
      .INDEX    (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .wr_idx   (wr_idx),
      .wr_file  (wr_file),
      .wr_tag   (wr_tag),
      .nbr_file (cell_file[NBR]),
      .nbr_tag  (cell_tag[NBR]),
      .file_q   (cell_file[i]),
      .tag_q    (cell_tag[i])
    );
  end

  // An accepted request keeps the block busy for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while a scan was starting");

  // A full table reports the full count.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_FULL) |-> rsp.entry_count == COUNT_W'(ENTRIES))
    else $error("full status with a count below capacity");

  // Only a successful request removes entries.
  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.removed_count != '0) |-> rsp.status == ST_OK)
    else $error("entries removed by a failed request");

  // A duplicate insert removes nothing.
  a_dup_no_remove: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_DUP) |-> rsp.removed_count == '0)
    else $error("duplicate insert removed entries");

endmodule
